### rtl/oli_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list package
// Beat types, request kinds and status codes of the list; the checker uses
// the response beat and the status codes.
// ----------------------------------------------------------------------------
package oli_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_TRAVERSE   = 3'd6;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_beat_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic [POS_W-1:0]          item_index;
        logic [POS_W-1:0]          entry_count;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } rsp_beat_t;

endpackage

### rtl/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Ordered list with insert and delete
// Keeps up to CAPACITY signed values in one synchronous memory.
// ----------------------------------------------------------------------------
// A request beat on req carries a kind, a value and a one-based position.
// Push, insert, pop and erase return one response beat with the new entry
// count and a status; traverse returns one beat per stored entry, in order,
// with last set on the final one (an empty list gives one ignored beat).
// Entries move one slot per cycle through the single memory, which has
// one read and one write port; an insert or delete passes through the
// shift state and then the response state, while a request that is
// ignored or refused as full goes straight to the response state.
// A traverse reads its entries in order, yields its first beat and
// then one beat per cycle while rsp is not stalled.
// One request is worked on at a time: req_stall is high from the cycle after
// a request is taken until its last response beat is in the output register.
// The output register holds a stalled beat, and the next request is taken
// while it waits. Reset empties the list and drops any pending beat.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  oli_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output oli_pkg::rsp_beat_t rsp
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > oli_pkg::POS_W) ? CW : oli_pkg::POS_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_TRAV,
        ST_RESP
    } state_t;

    logic signed [oli_pkg::VALUE_W-1:0] entry_mem [CAPACITY];
    logic signed [oli_pkg::VALUE_W-1:0] rd_data_reg;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic                           insert_reg, insert_next;
    logic signed [oli_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [AW-1:0]                  slot_reg, slot_next;
    logic [AW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [AW-1:0]                  wr_idx_reg, wr_idx_next;
    logic [CW-1:0]                  moves_reg, moves_next;
    logic                           pend_reg, pend_next;
    logic [oli_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [CW-1:0]                  emit_reg, emit_next;
    logic [CW-1:0]                  trav_idx_reg, trav_idx_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    oli_pkg::rsp_beat_t             rsp_reg, rsp_next;

    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic signed [oli_pkg::VALUE_W-1:0] mem_wdata;
    logic                           mem_re;
    logic [AW-1:0]                  mem_raddr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= entry_mem[mem_raddr];
        end
    end

    always_comb
    begin
        logic          out_free;
        logic          full;
        logic          empty;
        logic          pos_ok;
        logic          do_ins;
        logic          do_rem;
        logic [CW-1:0] slot;
        logic          take;
        logic          is_last;

        state_next     = state_reg;
        count_next     = count_reg;
        insert_next    = insert_reg;
        value_next     = value_reg;
        slot_next      = slot_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        moves_next     = moves_reg;
        pend_next      = pend_reg;
        status_next    = status_reg;
        emit_next      = emit_reg;
        trav_idx_next  = trav_idx_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        mem_we    = 1'b0;
        mem_waddr = wr_idx_reg;
        mem_wdata = rd_data_reg;
        mem_re    = 1'b0;
        mem_raddr = rd_idx_reg;

        out_free = !rsp_valid_reg || !rsp_stall;
        full     = (count_reg == CW'(CAPACITY));
        empty    = (count_reg == '0);
        pos_ok   = (req.position != '0) && (CMPW'(req.position) <= CMPW'(count_reg));
        do_ins   = 1'b0;
        do_rem   = 1'b0;
        slot     = '0;
        take     = pend_reg && out_free;
        is_last  = (CW'(emit_reg + CW'(1)) == count_reg);

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    value_next  = req.value;
                    status_next = oli_pkg::STATUS_DONE;
                    state_next  = ST_RESP;
                    case (req.kind)
                        oli_pkg::KIND_PUSH_FRONT:
                        begin
                            if (full) status_next = oli_pkg::STATUS_FULL;
                            else do_ins = 1'b1;
                        end
                        oli_pkg::KIND_PUSH_BACK:
                        begin
                            if (full) status_next = oli_pkg::STATUS_FULL;
                            else
                            begin
                                do_ins = 1'b1;
                                slot   = count_reg;
                            end
                        end
                        oli_pkg::KIND_INSERT:
                        begin
                            if (full) status_next = oli_pkg::STATUS_FULL;
                            else if (!pos_ok) status_next = oli_pkg::STATUS_IGNORED;
                            else
                            begin
                                do_ins = 1'b1;
                                slot   = (req.position == oli_pkg::POS_W'(1)) ? '0
                                         : CW'(req.position);
                            end
                        end
                        oli_pkg::KIND_POP_FRONT:
                        begin
                            if (empty) status_next = oli_pkg::STATUS_IGNORED;
                            else do_rem = 1'b1;
                        end
                        oli_pkg::KIND_POP_BACK:
                        begin
                            if (empty) status_next = oli_pkg::STATUS_IGNORED;
                            else
                            begin
                                do_rem = 1'b1;
                                slot   = CW'(count_reg - CW'(1));
                            end
                        end
                        oli_pkg::KIND_ERASE:
                        begin
                            if (!pos_ok) status_next = oli_pkg::STATUS_IGNORED;
                            else
                            begin
                                do_rem = 1'b1;
                                slot   = CW'(CW'(req.position) - CW'(1));
                            end
                        end
                        oli_pkg::KIND_TRAVERSE:
                        begin
                            if (empty) status_next = oli_pkg::STATUS_IGNORED;
                            else
                            begin
                                state_next    = ST_TRAV;
                                trav_idx_next = '0;
                                emit_next     = '0;
                                pend_next     = 1'b0;
                            end
                        end
                        default:
                        begin
                            status_next = oli_pkg::STATUS_IGNORED;
                        end
                    endcase

                    if (do_ins)
                    begin
                        state_next  = ST_SHIFT;
                        insert_next = 1'b1;
                        slot_next   = AW'(slot);
                        moves_next  = CW'(count_reg - slot);
                        rd_idx_next = AW'(count_reg - CW'(1));
                        pend_next   = 1'b0;
                    end
                    else if (do_rem)
                    begin
                        state_next  = ST_SHIFT;
                        insert_next = 1'b0;
                        slot_next   = AW'(slot);
                        moves_next  = CW'(count_reg - CW'(1) - slot);
                        rd_idx_next = AW'(slot + CW'(1));
                        pend_next   = 1'b0;
                    end
                end
            end

            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_idx_reg;
                    mem_wdata = rd_data_reg;
                end
                if (moves_reg != '0)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = rd_idx_reg;
                    pend_next  = 1'b1;
                    moves_next = CW'(moves_reg - CW'(1));
                    if (insert_reg)
                    begin
                        wr_idx_next = AW'(rd_idx_reg + AW'(1));
                        rd_idx_next = AW'(rd_idx_reg - AW'(1));
                    end
                    else
                    begin
                        wr_idx_next = AW'(rd_idx_reg - AW'(1));
                        rd_idx_next = AW'(rd_idx_reg + AW'(1));
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (insert_reg)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = slot_reg;
                            mem_wdata  = value_reg;
                            count_next = CW'(count_reg + CW'(1));
                        end
                        else
                        begin
                            count_next = CW'(count_reg - CW'(1));
                        end
                        state_next = ST_RESP;
                    end
                end
            end

            ST_TRAV:
            begin
                if (take)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.item_value  = rd_data_reg;
                    rsp_next.item_index  = oli_pkg::POS_W'(emit_reg + CW'(1));
                    rsp_next.entry_count = oli_pkg::POS_W'(count_reg);
                    rsp_next.status      = oli_pkg::STATUS_DONE;
                    rsp_next.last        = is_last;
                    emit_next            = CW'(emit_reg + CW'(1));
                    pend_next            = 1'b0;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                if ((!pend_reg || take) && (trav_idx_reg != count_reg))
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = AW'(trav_idx_reg);
                    pend_next     = 1'b1;
                    trav_idx_next = CW'(trav_idx_reg + CW'(1));
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.item_value  = '0;
                    rsp_next.item_index  = '0;
                    rsp_next.entry_count = oli_pkg::POS_W'(count_reg);
                    rsp_next.status      = status_reg;
                    rsp_next.last        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            moves_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            moves_reg     <= moves_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        insert_reg   <= insert_next;
        value_reg    <= value_next;
        slot_reg     <= slot_next;
        rd_idx_reg   <= rd_idx_next;
        wr_idx_reg   <= wr_idx_next;
        status_reg   <= status_next;
        emit_reg     <= emit_next;
        trav_idx_reg <= trav_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/oli_checker.sv
// ----------------------------------------------------------------------------
// Ordered list port checker
// Watches the request and response channels of the ordered list.
// ----------------------------------------------------------------------------
module oli_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input oli_pkg::rsp_beat_t rsp
);

    // A stalled response beat stays in place unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    // Only one request is worked on at a time.
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while another was in progress");

    // A beat that reports a problem carries no entry.
    a_no_entry_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != oli_pkg::STATUS_DONE)
        |-> (rsp.item_index == '0) && (rsp.item_value == '0) && rsp.last)
        else $error("ignored or full beat carries an entry");

    // The status code is never outside its defined set.
    a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == oli_pkg::STATUS_DONE)
                   || (rsp.status == oli_pkg::STATUS_IGNORED)
                   || (rsp.status == oli_pkg::STATUS_FULL))
        else $error("undefined status code");

endmodule

bind ordered_list_insert_delete oli_checker u_oli_checker (.*);
